// ----- hw/rtl/swk_pkg.sv -----
package swk_pkg;

  localparam int CordicSteps = 16;
  localparam int SqrtSteps   = 17;

  // pi in Q.16 radians, clamp limit in Q3.13
  localparam logic signed [20:0] AngPiQ16  = 21'sd205887;
  localparam logic signed [20:0] AngMaxQ13 = 21'sd25736;

  // round(atan(2^-i) * 2^16)
  function automatic logic signed [20:0] atan_q16(input logic [3:0] idx);
    logic signed [20:0] v;
    case (idx)
      4'd0:    v = 21'sd51472;
      4'd1:    v = 21'sd30386;
      4'd2:    v = 21'sd16055;
      4'd3:    v = 21'sd8150;
      4'd4:    v = 21'sd4091;
      4'd5:    v = 21'sd2047;
      4'd6:    v = 21'sd1024;
      4'd7:    v = 21'sd512;
      4'd8:    v = 21'sd256;
      4'd9:    v = 21'sd128;
      4'd10:   v = 21'sd64;
      4'd11:   v = 21'sd32;
      4'd12:   v = 21'sd16;
      4'd13:   v = 21'sd8;
      4'd14:   v = 21'sd4;
      4'd15:   v = 21'sd2;
      default: v = 21'sd0;
    endcase
    return v;
  endfunction

endpackage

// ----- hw/rtl/swerve_wheel_kinematics.sv -----
// Swerve inverse kinematics: one body velocity command in, speed and steering
// angle for the four wheel modules out. A new item may be started every clock
// while busy_o is low; its result is marked by a one-cycle done_o strobe and
// cannot be held off. The per-item path is a 23-stage pipeline (term multiply,
// squares, a 17-step square root and a 16-step CORDIC run one stage per step).
// busy_o is high after reset and after every register write while the two
// geometry ratios are recomputed by a shared bit-serial divider and square
// root.
module swerve_wheel_kinematics (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic signed [15:0] fwd_velocity_i,
  input  logic signed [15:0] side_velocity_i,
  input  logic signed [15:0] yaw_rate_i,
  input  logic               cfg_we_i,
  input  logic               cfg_idx_i,
  input  logic        [15:0] cfg_data_i,
  output logic               done_o,
  output logic        [15:0] fl_speed_o,
  output logic        [15:0] fr_speed_o,
  output logic        [15:0] rl_speed_o,
  output logic        [15:0] rr_speed_o,
  output logic signed [15:0] fl_angle_o,
  output logic signed [15:0] fr_angle_o,
  output logic signed [15:0] rl_angle_o,
  output logic signed [15:0] rr_angle_o
);
  import swk_pkg::*;

  localparam logic RegWheelBase  = 1'b0;
  localparam logic RegTrackWidth = 1'b1;

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StMul  = 3'd1;
  localparam logic [2:0] StSum  = 3'd2;
  localparam logic [2:0] StDiv  = 3'd3;
  localparam logic [2:0] StSqrt = 3'd4;

  localparam int NumIt = SqrtSteps + 1;

  // term index used as forward / lateral component per lane (FL, FR, RL, RR)
  localparam int FwdSel [4] = '{1, 1, 0, 0};
  localparam int LatSel [4] = '{2, 3, 2, 3};

  // ---------------- configuration and ratio unit ----------------
  logic [15:0] wb_len_q, tw_len_q;
  logic [15:0] kl_q, kw_q;
  logic [2:0]  st_q;
  logic        sel_q;
  logic [4:0]  cnt_q;
  logic [31:0] nsq_q, osq_q;
  logic [32:0] s_q;
  logic [33:0] rem_div_q;
  logic [30:0] quo_q;
  logic [30:0] sqn_q;
  logic [31:0] sqr_q;
  logic [30:0] sqb_q;

  logic [15:0] num, oth;
  logic        div_ge;
  logic [33:0] div_diff;
  logic [31:0] sq_trial;
  logic        sq_ge;
  logic [30:0] sqn_nx;
  logic [31:0] sqr_nx;
  logic [15:0] k_res;

  assign num      = sel_q ? tw_len_q : wb_len_q;
  assign oth      = sel_q ? wb_len_q : tw_len_q;
  assign div_ge   = rem_div_q >= {1'b0, s_q};
  assign div_diff = div_ge ? rem_div_q - {1'b0, s_q} : rem_div_q;
  assign sq_trial = sqr_q + {1'b0, sqb_q};
  assign sq_ge    = {1'b0, sqn_q} >= sq_trial;
  assign sqn_nx   = sq_ge ? 31'({1'b0, sqn_q} - sq_trial) : sqn_q;
  assign sqr_nx   = sq_ge ? (sqr_q >> 1) + {1'b0, sqb_q} : sqr_q >> 1;
  assign k_res    = (s_q == 33'd0) ? 16'd0 : sqr_nx[15:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wb_len_q <= 16'd2048;
      tw_len_q <= 16'd1638;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == RegWheelBase) wb_len_q <= cfg_data_i;
      if (cfg_idx_i == RegTrackWidth) tw_len_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= StMul;
      sel_q <= 1'b0;
      cnt_q <= 5'd0;
    end else if (cfg_we_i) begin
      st_q  <= StMul;
      sel_q <= 1'b0;
    end else begin
      case (st_q)
        StIdle: ;
        StMul:  st_q <= StSum;
        StSum: begin
          cnt_q <= 5'd30;
          st_q  <= StDiv;
        end
        StDiv: begin
          if (cnt_q == 5'd0) begin
            cnt_q <= 5'd15;
            st_q  <= StSqrt;
          end else begin
            cnt_q <= cnt_q - 5'd1;
          end
        end
        StSqrt: begin
          if (cnt_q == 5'd0) begin
            sel_q <= 1'b1;
            st_q  <= sel_q ? StIdle : StMul;
          end else begin
            cnt_q <= cnt_q - 5'd1;
          end
        end
        default: st_q <= StIdle;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kl_q <= 16'd0;
      kw_q <= 16'd0;
    end else if (st_q == StSqrt && cnt_q == 5'd0) begin
      if (sel_q) kw_q <= k_res;
      else       kl_q <= k_res;
    end
  end

  always_ff @(posedge clk_i) begin
    case (st_q)
      StMul: begin
        nsq_q <= num * num;
        osq_q <= oth * oth;
      end
      StSum: begin
        s_q       <= {1'b0, nsq_q} + {1'b0, osq_q};
        rem_div_q <= {2'b00, nsq_q};
        quo_q     <= 31'd0;
      end
      StDiv: begin
        quo_q     <= {quo_q[29:0], div_ge};
        rem_div_q <= {div_diff[32:0], 1'b0};
        if (cnt_q == 5'd0) begin
          sqn_q <= {quo_q[29:0], div_ge};
          sqr_q <= 32'd0;
          sqb_q <= 31'd1 << 30;
        end
      end
      StSqrt: begin
        sqn_q <= sqn_nx;
        sqr_q <= sqr_nx;
        sqb_q <= sqb_q >> 2;
      end
      default: ;
    endcase
  end

  assign busy_o = (st_q != StIdle);

  // ---------------- item pipeline ----------------
  logic va_q, vb_q, vc_q, vd_q;
  logic v_q [NumIt];
  logic done_q;

  logic signed [15:0] vx_a_q, vy_a_q, w_a_q;
  logic signed [15:0] vx_b_q, vy_b_q;
  logic signed [32:0] pl_b_q, pw_b_q;
  logic signed [17:0] term_c_q [4];
  logic signed [17:0] term_d_q [4];
  logic        [32:0] sq_d_q   [4];

  logic        [33:0] rem_q [4][NumIt];
  logic        [34:0] res_q [4][NumIt];
  logic signed [36:0] cx_q  [4][NumIt];
  logic signed [36:0] cy_q  [4][NumIt];
  logic signed [20:0] cz_q  [4][NumIt];
  logic               zf_q  [4][NumIt];

  logic        [15:0] spd_q [4];
  logic signed [15:0] ang_q [4];

  logic               accept;
  logic signed [16:0] kl_s, kw_s;
  logic signed [32:0] pl_d, pw_d;
  logic signed [33:0] acc_d [4];

  assign accept = start_i & ~busy_o;
  assign kl_s   = {1'b0, kl_q};
  assign kw_s   = {1'b0, kw_q};
  assign pl_d   = w_a_q * kl_s;
  assign pw_d   = w_a_q * kw_s;

  always_comb begin
    acc_d[0] = (34'(vx_b_q) <<< 15) - 34'(pl_b_q) + 34'sd16384;
    acc_d[1] = (34'(vx_b_q) <<< 15) + 34'(pl_b_q) + 34'sd16384;
    acc_d[2] = (34'(vy_b_q) <<< 15) - 34'(pw_b_q) + 34'sd16384;
    acc_d[3] = (34'(vy_b_q) <<< 15) + 34'(pw_b_q) + 34'sd16384;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q   <= 1'b0;
      vb_q   <= 1'b0;
      vc_q   <= 1'b0;
      vd_q   <= 1'b0;
      done_q <= 1'b0;
      for (int k = 0; k < NumIt; k++) v_q[k] <= 1'b0;
    end else begin
      va_q   <= accept;
      vb_q   <= va_q;
      vc_q   <= vb_q;
      vd_q   <= vc_q;
      v_q[0] <= vd_q;
      for (int k = 1; k < NumIt; k++) v_q[k] <= v_q[k-1];
      done_q <= v_q[NumIt-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      vx_a_q <= fwd_velocity_i;
      vy_a_q <= side_velocity_i;
      w_a_q  <= yaw_rate_i;
    end
    vx_b_q <= vx_a_q;
    vy_b_q <= vy_a_q;
    pl_b_q <= pl_d;
    pw_b_q <= pw_d;
    for (int i = 0; i < 4; i++) begin
      term_c_q[i] <= 18'(acc_d[i] >>> 15);
      term_d_q[i] <= term_c_q[i];
    end
  end

  for (genvar i = 0; i < 4; i++) begin : g_sq
    logic signed [35:0] prod;
    assign prod = term_c_q[i] * term_c_q[i];
    always_ff @(posedge clk_i) sq_d_q[i] <= prod[32:0];
  end

  for (genvar j = 0; j < 4; j++) begin : g_lane
    logic signed [17:0] f, l;
    logic signed [36:0] x0, y0;
    logic        [34:0] s_rnd;
    logic signed [20:0] z_rnd;

    assign f  = term_d_q[FwdSel[j]];
    assign l  = term_d_q[LatSel[j]];
    assign x0 = 37'(l) <<< 16;
    assign y0 = 37'(f) <<< 16;

    // entry: magnitude sum and CORDIC prerotation into the right half plane
    always_ff @(posedge clk_i) begin
      rem_q[j][0] <= 34'(sq_d_q[FwdSel[j]]) + 34'(sq_d_q[LatSel[j]]);
      res_q[j][0] <= 35'd0;
      zf_q[j][0]  <= (f == 18'sd0) && (l == 18'sd0);
      if (l < 18'sd0) begin
        cx_q[j][0] <= -x0;
        cy_q[j][0] <= -y0;
        cz_q[j][0] <= (f >= 18'sd0) ? AngPiQ16 : -AngPiQ16;
      end else begin
        cx_q[j][0] <= x0;
        cy_q[j][0] <= y0;
        cz_q[j][0] <= 21'sd0;
      end
    end

    for (genvar k = 0; k < SqrtSteps; k++) begin : g_it
      localparam logic [34:0] Bit = 35'd1 << (32 - 2 * k);
      logic [34:0] trial;
      logic        ge;

      assign trial = res_q[j][k] + Bit;
      assign ge    = {1'b0, rem_q[j][k]} >= trial;

      always_ff @(posedge clk_i) begin
        zf_q[j][k+1] <= zf_q[j][k];
        if (ge) begin
          rem_q[j][k+1] <= 34'({1'b0, rem_q[j][k]} - trial);
          res_q[j][k+1] <= (res_q[j][k] >> 1) + Bit;
        end else begin
          rem_q[j][k+1] <= rem_q[j][k];
          res_q[j][k+1] <= res_q[j][k] >> 1;
        end
      end

      if (k < CordicSteps) begin : g_rot
        always_ff @(posedge clk_i) begin
          if (cy_q[j][k] > 37'sd0) begin
            cx_q[j][k+1] <= cx_q[j][k] + (cy_q[j][k] >>> k);
            cy_q[j][k+1] <= cy_q[j][k] - (cx_q[j][k] >>> k);
            cz_q[j][k+1] <= cz_q[j][k] + atan_q16(4'(k));
          end else begin
            cx_q[j][k+1] <= cx_q[j][k] - (cy_q[j][k] >>> k);
            cy_q[j][k+1] <= cy_q[j][k] + (cx_q[j][k] >>> k);
            cz_q[j][k+1] <= cz_q[j][k] - atan_q16(4'(k));
          end
        end
      end else begin : g_hold
        always_ff @(posedge clk_i) begin
          cx_q[j][k+1] <= cx_q[j][k];
          cy_q[j][k+1] <= cy_q[j][k];
          cz_q[j][k+1] <= cz_q[j][k];
        end
      end
    end

    // round to nearest: remainder above root means the next integer is closer
    assign s_rnd = ({1'b0, rem_q[j][NumIt-1]} > res_q[j][NumIt-1]) ?
                   res_q[j][NumIt-1] + 35'd1 : res_q[j][NumIt-1];
    assign z_rnd = (cz_q[j][NumIt-1] + 21'sd4) >>> 3;

    always_ff @(posedge clk_i) begin
      spd_q[j] <= (s_rnd > 35'd65535) ? 16'hFFFF : s_rnd[15:0];
      if (zf_q[j][NumIt-1])            ang_q[j] <= 16'sd0;
      else if (z_rnd > AngMaxQ13)      ang_q[j] <= 16'(AngMaxQ13);
      else if (z_rnd < -AngMaxQ13)     ang_q[j] <= 16'(-AngMaxQ13);
      else                             ang_q[j] <= z_rnd[15:0];
    end
  end

  assign done_o     = done_q;
  assign fl_speed_o = spd_q[0];
  assign fr_speed_o = spd_q[1];
  assign rl_speed_o = spd_q[2];
  assign rr_speed_o = spd_q[3];
  assign fl_angle_o = ang_q[0];
  assign fr_angle_o = ang_q[1];
  assign rl_angle_o = ang_q[2];
  assign rr_angle_o = ang_q[3];

`ifndef SYNTHESIS
  a_no_start_when_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && busy_o |=> !va_q)
    else $error("item entered while ratios were being recomputed");

  a_cfg_starts_ratio: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |=> busy_o)
    else $error("register write did not restart ratio unit");

  a_ratio_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    kl_q <= 16'd32768 && kw_q <= 16'd32768)
    else $error("geometry ratio above 1.0");

  a_angle_clamp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> fl_angle_o <= 16'sd25736 && fl_angle_o >= -16'sd25736)
    else $error("front left angle outside clamp");
`endif

endmodule
